/* rtl/cascaded_countdown_timer_bank_assert.svh */
// ----------------------------------------------------------------------------
// cascaded countdown timer bank assertion macros
// clocked assertion helpers used by the timer bank rtl
// ----------------------------------------------------------------------------
`ifndef CASCADED_COUNTDOWN_TIMER_BANK_ASSERT_SVH
`define CASCADED_COUNTDOWN_TIMER_BANK_ASSERT_SVH

// assertion on an explicit clock and active-low reset
`define CCDT_ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// assertion on the block clock and reset
`define CCDT_ASSERT(lbl, prop, msg) \
  `CCDT_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

/* rtl/ccdt_pkg.sv */
// ----------------------------------------------------------------------------
// ccdt_pkg
// types and constants of the cascaded countdown timer bank
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccdt_pkg;

  localparam int unsigned NUM_TIMERS  = 8;
  localparam int unsigned TIMER_IDX_W = 3;
  localparam int unsigned COUNT_W     = 10;
  localparam int unsigned ELAPSED_W   = 15;
  localparam int unsigned PERIOD_W    = 16;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    OFF_BACKUP  = 2'd0,
    OFF_CONTROL = 2'd1,
    OFF_COUNTER = 2'd2,
    OFF_DYNAMIC = 2'd3
  } timer_off_e;

  localparam logic [7:0] ADDR_TIMER_END = 8'h20;
  localparam logic [7:0] ADDR_CLEAR     = 8'h80;
  localparam logic [7:0] ADDR_STATUS    = 8'h81;

  localparam int unsigned CTRL_IRQ_BIT    = 7;
  localparam int unsigned CTRL_RELOAD_BIT = 4;
  localparam int unsigned CTRL_ENABLE_BIT = 3;
  localparam logic [2:0]  LINK_CODE       = 3'd7;
  localparam int unsigned STATUS_RD_CLR   = 4;

  localparam logic [8:0]         FULL_PERIOD = 9'h100;
  localparam logic [COUNT_W-1:0] COUNT_STOP  = 10'h3ff;

  // cascade source of each timer: 0->2->4, 1->3->5->7
  localparam logic [NUM_TIMERS-1:0] HAS_SRC = 8'b1011_1100;
  localparam logic [TIMER_IDX_W-1:0] SRC_IDX [NUM_TIMERS] = '{
    3'd0, 3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd5
  };

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] address;
    logic [7:0] write_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_pulse;
    logic [7:0] fired_timers;
  } rsp_t;

endpackage

/* rtl/cascaded_countdown_timer_bank.sv */
// ----------------------------------------------------------------------------
// cascaded countdown timer bank
// response: the request is held in the input reg, its result in the result reg
// throughput: one request per cycle unless out_ready_i stalls the output; all
// eight timers and the cascade update combinationally from input to result reg
// reset: asynchronous active low, clears all timer state, status and handshakes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cascaded_countdown_timer_bank_assert.svh"

module cascaded_countdown_timer_bank (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ccdt_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ccdt_pkg::rsp_t out_rsp_o
);
  import ccdt_pkg::*;

  req_t                 req_q;
  logic                 req_vld_q;
  rsp_t                 rsp_q, rsp_d;
  logic                 out_vld_q;
  logic                 adv;

  logic [7:0]           backup_q  [NUM_TIMERS];
  logic [7:0]           backup_d  [NUM_TIMERS];
  logic [7:0]           ctrl_q    [NUM_TIMERS];
  logic [7:0]           ctrl_d    [NUM_TIMERS];
  logic [7:0]           dyn_q     [NUM_TIMERS];
  logic [7:0]           dyn_d     [NUM_TIMERS];
  logic [COUNT_W-1:0]   cnt_q     [NUM_TIMERS];
  logic [COUNT_W-1:0]   cnt_d     [NUM_TIMERS];
  logic [ELAPSED_W-1:0] elapsed_q [NUM_TIMERS];
  logic [ELAPSED_W-1:0] elapsed_d [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] armed_q, armed_d;
  logic [7:0]           status_q, status_d;

  logic [NUM_TIMERS-1:0] linked;
  logic [NUM_TIMERS-1:0] direct;
  logic [NUM_TIMERS-1:0] fire;
  logic [NUM_TIMERS-1:0] step;
  logic [NUM_TIMERS-1:0] irq_hit;
  logic [ELAPSED_W-1:0]  einc [NUM_TIMERS];
  logic [PERIOD_W-1:0]   period [NUM_TIMERS];

  logic                   is_tick, is_read, is_write, in_timer;
  logic [TIMER_IDX_W-1:0] tidx;
  logic [1:0]             toff;

  // handshake
  assign adv         = req_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !req_vld_q || adv;
  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        req_vld_q <= 1'b1;
      end else if (adv) begin
        req_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
    if (adv) begin
      rsp_q <= rsp_d;
    end
  end

  // decode
  assign is_tick  = (req_q.action == ACT_TICK);
  assign is_read  = (req_q.action == ACT_READ);
  assign is_write = (req_q.action == ACT_WRITE);
  assign in_timer = (req_q.address < ADDR_TIMER_END);
  assign tidx     = req_q.address[4:2];
  assign toff     = req_q.address[1:0];

  // per-timer tick logic
  always_comb begin
    for (int n = 0; n < NUM_TIMERS; n++) begin
      linked[n] = (ctrl_q[n][2:0] == LINK_CODE);
      einc[n]   = elapsed_q[n] + ELAPSED_W'(1);
      period[n] = PERIOD_W'((backup_q[n] == 8'd0) ? FULL_PERIOD : {1'b0, backup_q[n]})
                  << ctrl_q[n][2:0];
      direct[n] = is_tick && armed_q[n] && ({1'b0, einc[n]} >= period[n]);
    end
  end

  // cascade, sources always have a lower index
  always_comb begin
    fire = direct;
    step = '0;
    for (int n = 0; n < NUM_TIMERS; n++) begin
      if (HAS_SRC[n] && fire[SRC_IDX[n]] && linked[n] && !cnt_q[n][COUNT_W-1]) begin
        step[n] = 1'b1;
        if (cnt_q[n] == '0) begin
          fire[n] = 1'b1;
        end
      end
    end
    for (int n = 0; n < NUM_TIMERS; n++) begin
      irq_hit[n] = fire[n] && ctrl_q[n][CTRL_IRQ_BIT];
    end
  end

  // next state and response
  always_comb begin
    backup_d  = backup_q;
    ctrl_d    = ctrl_q;
    dyn_d     = dyn_q;
    cnt_d     = cnt_q;
    elapsed_d = elapsed_q;
    armed_d   = armed_q;
    status_d  = status_q;
    rsp_d     = '0;

    if (is_tick) begin
      for (int n = 0; n < NUM_TIMERS; n++) begin
        if (armed_q[n]) begin
          elapsed_d[n] = direct[n] ? '0 : einc[n];
          if (direct[n] && !ctrl_q[n][CTRL_RELOAD_BIT]) begin
            armed_d[n] = 1'b0;
          end
        end
        if (step[n]) begin
          if (cnt_q[n] != '0) begin
            cnt_d[n] = cnt_q[n] - COUNT_W'(1);
          end else begin
            cnt_d[n] = ctrl_q[n][CTRL_RELOAD_BIT] ? {2'b00, backup_q[n]} : COUNT_STOP;
          end
        end
      end
      status_d           = status_q | irq_hit;
      rsp_d.fired_timers = fire;
      rsp_d.irq_pulse    = |irq_hit;
    end else if (is_read) begin
      if (in_timer) begin
        unique case (timer_off_e'(toff))
          OFF_BACKUP:  rsp_d.read_data = backup_q[tidx];
          OFF_CONTROL: rsp_d.read_data = ctrl_q[tidx];
          OFF_COUNTER: rsp_d.read_data = cnt_q[tidx][7:0];
          OFF_DYNAMIC: rsp_d.read_data = dyn_q[tidx];
          default:     rsp_d.read_data = '0;
        endcase
      end else if (req_q.address == ADDR_STATUS) begin
        rsp_d.read_data          = status_q;
        status_d[STATUS_RD_CLR] = 1'b0;
      end
    end else if (is_write) begin
      if (in_timer) begin
        unique case (timer_off_e'(toff))
          OFF_BACKUP: begin
            backup_d[tidx] = req_q.write_data;
            cnt_d[tidx]    = {2'b00, req_q.write_data} + COUNT_W'(1);
          end
          OFF_CONTROL: ctrl_d[tidx] = req_q.write_data;
          OFF_COUNTER: ;
          OFF_DYNAMIC: dyn_d[tidx] = req_q.write_data;
          default: ;
        endcase
        armed_d[tidx] = 1'b0;
        if (ctrl_d[tidx][CTRL_ENABLE_BIT] && (ctrl_d[tidx][2:0] != LINK_CODE)) begin
          armed_d[tidx]   = 1'b1;
          elapsed_d[tidx] = '0;
        end
      end else if (req_q.address == ADDR_CLEAR) begin
        status_d = status_q & ~req_q.write_data;
      end else if (req_q.address == ADDR_STATUS) begin
        status_d = req_q.write_data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NUM_TIMERS; n++) begin
        backup_q[n]  <= '0;
        ctrl_q[n]    <= '0;
        dyn_q[n]     <= '0;
        cnt_q[n]     <= '0;
        elapsed_q[n] <= '0;
      end
      armed_q  <= '0;
      status_q <= '0;
    end else if (adv) begin
      backup_q  <= backup_d;
      ctrl_q    <= ctrl_d;
      dyn_q     <= dyn_d;
      cnt_q     <= cnt_d;
      elapsed_q <= elapsed_d;
      armed_q   <= armed_d;
      status_q  <= status_d;
    end
  end

  `CCDT_ASSERT(a_armed_not_linked, (armed_q & linked) == '0, "armed timer is linked")
  `CCDT_ASSERT(a_irq_needs_fire,
               out_valid_o && out_rsp_o.irq_pulse |-> out_rsp_o.fired_timers != '0,
               "irq without firing timer")
  `CCDT_ASSERT(a_fire_no_read_data,
               out_valid_o && (out_rsp_o.fired_timers != '0) |-> out_rsp_o.read_data == '0,
               "firing mixed with read data")
  `CCDT_ASSERT(a_irq_sets_status, adv && rsp_d.irq_pulse |=> status_q != '0,
               "irq left status empty")

endmodule
